// File: design/assert_macros.svh
// Assertion helpers shared by the RTL files.
// All checks sample on the rising edge of clock and stay quiet while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge.
`define FFST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a trigger implies a consequence on the next clock edge.
`define FFST_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ffst_pkg.sv
`default_nettype none

package ffst_pkg;

   localparam int MaxSlots  = 32;
   localparam int SlotW     = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
   localparam int CapW      = 6;
   localparam int IdxW      = 8;
   localparam int CmpW      = ((IdxW > CapW) ? IdxW : CapW) + 1;
   localparam int PosW      = 16;
   localparam int HandleW   = 16;
   localparam int SlotOutW  = 5;
   localparam int CmdW      = 2;
   localparam int ReqDataW  = 56;
   localparam int RspDataW  = 24;

   localparam logic [CapW-1:0] CapReset = CapW'(32);

   typedef enum logic [CmdW-1:0] {
      CmdAdd       = 2'd0,
      CmdRemove    = 2'd1,
      CmdTranslate = 2'd2,
      CmdGet       = 2'd3
   } command_type;

   // Clamps a programmed capacity to the number of physical slots.
   function automatic logic [CmpW-1:0] eff_cap_f(input logic [CapW-1:0] cap);
      logic [CmpW-1:0] wide;
      wide = CmpW'(cap);
      eff_cap_f = (wide < CmpW'(MaxSlots)) ? wide : CmpW'(MaxSlots);
   endfunction

   // One bit per slot, set for slots below the effective capacity.
   function automatic logic [MaxSlots-1:0] cap_mask_f(input logic [CapW-1:0] cap);
      logic [CmpW-1:0] ecap;
      ecap = eff_cap_f(cap);
      for (int i = 0; i < MaxSlots; i++) begin
         cap_mask_f[i] = CmpW'(i) < ecap;
      end
   endfunction

endpackage

`default_nettype wire

// File: design/first_free_slot_table_unit.sv
`default_nettype none

// Slot table with first-free allocation. Each request transaction carries one of four
// commands: add claims the lowest free slot below the programmed capacity and stores the
// item handle and x/y position there, remove frees an occupied slot, translate gives an
// occupied slot a new position, and get returns the handle of an occupied slot. Every
// request produces exactly one response transaction with an ok flag, the slot claimed by
// a successful add and the handle returned by a successful get (both zero otherwise).
// Occupancy is held in one flip-flop per slot, so the free-slot search is a single
// priority encoder; positions and handles live in synchronous memories, and the handle
// read is registered. A command is accepted every cycle as long as the response register
// is empty or being drained, and its response appears in the cycle after acceptance. The
// capacity register must be written through the csr port only while no command is in
// flight (not enforced here); lowering it frees every slot at or above the new capacity.
module first_free_slot_table_unit
   import ffst_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   // Capacity register write channel.
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire  [CapW-1:0]           csr_data,      // slot_capacity
   // Command channel.
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  wire  [ReqDataW-1:0]       req_tdata,     // slot_index, x_pos, y_pos, item_handle
   input  wire  [CmdW-1:0]           req_tuser,     // command
   // Response channel.
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   output logic [RspDataW-1:0]       rsp_tdata      // ok, slot_out, handle_out, zero pad
);

`include "assert_macros.svh"

   // Request fields.
   command_type          req_cmd;
   logic [IdxW-1:0]      req_idx;
   logic [PosW-1:0]      req_x;
   logic [PosW-1:0]      req_y;
   logic [HandleW-1:0]   req_handle;
   logic                 req_accept;

   // Control state.
   logic [CapW-1:0]      capacity_ff;
   logic [CapW-1:0]      capacity_in;
   logic [MaxSlots-1:0]  valid_ff;
   logic [MaxSlots-1:0]  valid_in;

   // Response register.
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 ok_ff;
   logic                 ok_in;
   logic [SlotOutW-1:0]  slot_ff;
   logic [SlotOutW-1:0]  slot_in;
   logic                 get_hit_ff;
   logic                 get_hit_in;
   logic [HandleW-1:0]   rd_handle_ff;

   // Storage. Positions and handles are only meaningful for occupied slots.
   logic [2*PosW-1:0]    pos_mem [MaxSlots];
   logic [HandleW-1:0]   handle_mem [MaxSlots];

   // Decode.
   logic [MaxSlots-1:0]  cap_mask;
   logic [CmpW-1:0]      eff_cap;
   logic                 idx_in_range;
   logic                 hit;
   logic [SlotW-1:0]     slot_addr;
   logic                 free_found;
   logic [SlotW-1:0]     free_idx;
   logic                 add_ok;
   logic                 pos_we;
   logic [SlotW-1:0]     pos_waddr;

   assign req_cmd    = command_type'(req_tuser);
   assign req_idx    = req_tdata[IdxW-1:0];
   assign req_x      = req_tdata[IdxW +: PosW];
   assign req_y      = req_tdata[IdxW+PosW +: PosW];
   assign req_handle = req_tdata[IdxW+2*PosW +: HandleW];

   // The response register doubles as the only pipeline stage, so a new command can
   // enter in the same cycle that the previous response is taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign cap_mask     = cap_mask_f(capacity_ff);
   assign eff_cap      = eff_cap_f(capacity_ff);
   assign idx_in_range = CmpW'(req_idx) < eff_cap;
   // The slot address is only used when the index is in range, where it fits.
   assign slot_addr    = req_idx[SlotW-1:0];
   assign hit          = idx_in_range && valid_ff[slot_addr];

   // Priority encoder for the lowest free slot below the capacity.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MaxSlots - 1; i >= 0; i--) begin
         if (!valid_ff[i] && cap_mask[i]) begin
            free_found = 1'b1;
            free_idx   = SlotW'(i);
         end
      end
   end

   assign add_ok = (req_cmd == CmdAdd) && free_found;

   // Occupancy, outcome and next response.
   always_comb begin
      valid_in    = valid_ff;
      capacity_in = capacity_ff;
      ok_in       = 1'b0;
      slot_in     = '0;
      get_hit_in  = 1'b0;
      if (csr_valid && csr_ready) begin
         // Shrinking the table frees the slots that drop out of it.
         capacity_in = csr_data;
         valid_in    = valid_ff & cap_mask_f(csr_data);
      end
      if (req_accept) begin
         case (req_cmd)
            CmdAdd: begin
               if (free_found) begin
                  valid_in[free_idx] = 1'b1;
                  ok_in              = 1'b1;
                  slot_in            = SlotOutW'(free_idx);
               end
            end
            CmdRemove: begin
               if (hit) begin
                  valid_in[slot_addr] = 1'b0;
               end
               ok_in = 1'b1;
            end
            CmdTranslate: begin
               ok_in = hit;
            end
            CmdGet: begin
               ok_in      = hit;
               get_hit_in = hit;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);

   // Position memory: written by a successful add or translate.
   assign pos_we    = req_accept && (add_ok || ((req_cmd == CmdTranslate) && hit));
   assign pos_waddr = (req_cmd == CmdAdd) ? free_idx : slot_addr;

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= {req_y, req_x};
      end
   end

   // Handle memory: written by a successful add, read for every accepted command so the
   // data lines up with the response register. A read meets a write to the same slot only
   // during an add, whose response does not use the handle that was read.
   always_ff @(posedge clock) begin
      if (req_accept && add_ok) begin
         handle_mem[free_idx] <= req_handle;
      end
      if (req_accept) begin
         rd_handle_ff <= handle_mem[slot_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CapReset;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ok_ff      <= ok_in;
         slot_ff    <= slot_in;
         get_hit_ff <= get_hit_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataW'({(get_hit_ff ? rd_handle_ff : HandleW'(0)), slot_ff, ok_ff});

   // No slot at or above the capacity is ever marked occupied.
   `FFST_ASSERT(a_no_valid_above_cap, (valid_ff & ~cap_mask) == '0,
      "occupied slot found at or above capacity")

   // A successful add leaves its slot occupied.
   `FFST_ASSERT_NEXT(a_add_claims_slot, req_accept && add_ok, valid_ff[$past(free_idx)],
      "added slot not marked occupied")

   // A response waiting on a stalled consumer blocks new commands.
   `FFST_ASSERT(a_no_overrun, !(rsp_valid_ff && !rsp_tready && req_accept),
      "command accepted while response register is stalled")

endmodule

`default_nettype wire

// File: sim/testbench.sv
module testbench;
   import ffst_pkg::*;

   // Expected content of one response transaction.
   typedef struct packed {
      logic                ok;
      logic [SlotOutW-1:0] slot;
      logic [HandleW-1:0]  handle;
   } slot_result_type;

   // One row of the directed table: either a capacity write or a command. Typed rows
   // carry a hand-written response; the rest rely on the shadow table.
   typedef struct packed {
      bit                  is_cap;
      logic [CapW-1:0]     cap;
      command_type         cmd;
      logic [IdxW-1:0]     idx;
      logic [PosW-1:0]     x;
      logic [PosW-1:0]     y;
      logic [HandleW-1:0]  h;
      bit                  typed;
      logic                ok;
      logic [SlotOutW-1:0] slot;
      logic [HandleW-1:0]  handle;
   } directed_row_type;

   // One phase of the random part.
   typedef struct packed {
      logic [CapW-1:0] cap;
      int              idle_pct;
      int              stall_pct;
      int              add_pct;
      bit              hold_off;
   } phase_type;

   localparam int NumRows        = 25;
   localparam int NumPhases      = 8;
   localparam int ItemsPerPhase  = 88;
   localparam int HoldOffCycles  = 300;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CapW-1:0]     csr_data = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic [CmdW-1:0]     req_tuser = CmdAdd;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_requests  = 0;
   int error_count        = 0;

   // Shadow copy of the slot table and its capacity register.
   logic [CapW-1:0]    shadow_capacity = CapReset;
   bit                 shadow_busy   [MaxSlots];
   logic [PosW-1:0]    shadow_x      [MaxSlots];
   logic [PosW-1:0]    shadow_y      [MaxSlots];
   logic [HandleW-1:0] shadow_handle [MaxSlots];

   slot_result_type pending_results [$];

   directed_row_type directed_rows [NumRows] = '{
      //  cap  capacity cmd           idx     x         y         handle  typ ok  slot  handle
      '{1'b0, 6'd0,  CmdGet,       8'd0,   16'h0000, 16'h0000, 16'h0000, 1, 0, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdRemove,    8'd0,   16'h0000, 16'h0000, 16'h0000, 1, 1, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdTranslate, 8'd5,   16'h1111, 16'h2222, 16'h0000, 1, 0, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdAdd,       8'd0,   16'h0000, 16'h0000, 16'h0000, 1, 1, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdAdd,       8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 5'd1, 16'h0000},
      '{1'b0, 6'd0,  CmdGet,       8'd1,   16'h0000, 16'h0000, 16'h0000, 1, 1, 5'd0, 16'hFFFF},
      '{1'b0, 6'd0,  CmdGet,       8'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdTranslate, 8'd1,   16'h1234, 16'h5678, 16'h9ABC, 0, 0, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdGet,       8'd255, 16'h0000, 16'h0000, 16'h0000, 1, 0, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdRemove,    8'd255, 16'h0000, 16'h0000, 16'h0000, 1, 1, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdTranslate, 8'd32,  16'hAAAA, 16'h5555, 16'h0000, 1, 0, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdRemove,    8'd0,   16'h0000, 16'h0000, 16'h0000, 1, 1, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdAdd,       8'd0,   16'h00FF, 16'hFF00, 16'hA5A5, 1, 1, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdGet,       8'd31,  16'h0000, 16'h0000, 16'h0000, 1, 0, 5'd0, 16'h0000},
      // Capacity above the number of slots saturates and keeps every slot.
      '{1'b1, 6'd63, CmdAdd,       8'd0,   16'h0000, 16'h0000, 16'h0000, 0, 0, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdGet,       8'd1,   16'h0000, 16'h0000, 16'h0000, 1, 1, 5'd0, 16'hFFFF},
      // Two slots, both occupied: the table is full.
      '{1'b1, 6'd2,  CmdAdd,       8'd0,   16'h0000, 16'h0000, 16'h0000, 0, 0, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdAdd,       8'd0,   16'h7777, 16'h8888, 16'h9999, 1, 0, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdGet,       8'd2,   16'h0000, 16'h0000, 16'h0000, 1, 0, 5'd0, 16'h0000},
      // Zero capacity frees everything and refuses every add.
      '{1'b1, 6'd0,  CmdAdd,       8'd0,   16'h0000, 16'h0000, 16'h0000, 0, 0, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdAdd,       8'd0,   16'h4321, 16'h8765, 16'hCAFE, 1, 0, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdGet,       8'd0,   16'h0000, 16'h0000, 16'h0000, 1, 0, 5'd0, 16'h0000},
      // Raised again, the slots freed by the shrink stay empty.
      '{1'b1, 6'd32, CmdAdd,       8'd0,   16'h0000, 16'h0000, 16'h0000, 0, 0, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdGet,       8'd1,   16'h0000, 16'h0000, 16'h0000, 1, 0, 5'd0, 16'h0000},
      '{1'b0, 6'd0,  CmdAdd,       8'd9,   16'h0F0F, 16'hF0F0, 16'h0F0F, 0, 0, 5'd0, 16'h0000}
   };

   phase_type phases [NumPhases] = '{
      //  capacity idle stall add hold
      '{6'd32, 0,  0,  60, 1'b0},
      '{6'd32, 56, 0,  35, 1'b0},
      '{6'd1,  0,  56, 50, 1'b0},
      '{6'd7,  23, 23, 45, 1'b0},
      '{6'd0,  0,  0,  40, 1'b0},
      '{6'd63, 0,  0,  55, 1'b1},
      '{6'd31, 56, 56, 45, 1'b0},
      '{6'd17, 23, 23, 50, 1'b0}
   };

   first_free_slot_table_unit uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Number of usable slots: the capacity, saturated at the physical size.
   function automatic int usable_slots();
      return (int'(shadow_capacity) > MaxSlots) ? MaxSlots : int'(shadow_capacity);
   endfunction

   // Capacity write: slots at or above the new limit are released.
   function automatic void apply_capacity(input logic [CapW-1:0] cap);
      shadow_capacity = cap;
      for (int i = usable_slots(); i < MaxSlots; i++) begin
         shadow_busy[i] = 1'b0;
      end
   endfunction

   // Executes one command on the shadow table and returns its response.
   function automatic slot_result_type apply_command(input command_type cmd,
                                                   input logic [IdxW-1:0] idx,
                                                   input logic [PosW-1:0] x,
                                                   input logic [PosW-1:0] y,
                                                   input logic [HandleW-1:0] h);
      slot_result_type     r;
      int                  lim;
      bit                  hit;
      logic [SlotW-1:0]    s;
      r   = '0;
      lim = usable_slots();
      s   = idx[SlotW-1:0];
      hit = (int'(idx) < lim) && shadow_busy[s];
      case (cmd)
         CmdAdd: begin
            for (int i = 0; i < lim; i++) begin
               if (!r.ok && !shadow_busy[i]) begin
                  shadow_busy[i]   = 1'b1;
                  shadow_x[i]      = x;
                  shadow_y[i]      = y;
                  shadow_handle[i] = h;
                  r.ok             = 1'b1;
                  r.slot           = SlotOutW'(i);
               end
            end
         end
         CmdRemove: begin
            if (hit) shadow_busy[s] = 1'b0;
            r.ok = 1'b1;
         end
         CmdTranslate: begin
            if (hit) begin
               shadow_x[s] = x;
               shadow_y[s] = y;
               r.ok        = 1'b1;
            end
         end
         default: begin
            if (hit) begin
               r.ok     = 1'b1;
               r.handle = shadow_handle[s];
            end
         end
      endcase
      return r;
   endfunction

   // Offers one command transaction, with random idle cycles ahead of it, and records
   // the expected response once the block takes it.
   task automatic offer_command(input command_type cmd, input logic [IdxW-1:0] idx,
                                input logic [PosW-1:0] x, input logic [PosW-1:0] y,
                                input logic [HandleW-1:0] h, input bit typed,
                                input slot_result_type typed_result);
      slot_result_type want;
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {h, y, x, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = apply_command(cmd, idx, x, y, h);
      if (typed) want = typed_result;
      pending_results.push_back(want);
   endtask

   // Stops offering commands and waits until every response has been taken.
   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Writes the capacity register once the table has gone idle.
   task automatic write_capacity(input logic [CapW-1:0] cap);
      drain_responses();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_capacity(cap);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response sink: random stalls, plus a long hold-off whenever one is requested.
   initial begin : response_sink
      int hold_left;
      int hold_served;
      hold_left   = 0;
      hold_served = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_off_requests) begin
            hold_served = hold_off_requests;
            hold_left   = HoldOffCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Compares every response transaction with the oldest outstanding expectation.
   always @(posedge clock) begin : response_check
      slot_result_type want;
      slot_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok     = rsp_tdata[0];
         got.slot   = rsp_tdata[SlotOutW:1];
         got.handle = rsp_tdata[SlotOutW+HandleW:SlotOutW+1];
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response ok=%0d slot=%0d handle=%h",
                     $time, got.ok, got.slot, got.handle);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.ok !== want.ok || got.slot !== want.slot || got.handle !== want.handle)
            begin
               $display({"%0t: response mismatch: expected ok=%0d slot=%0d handle=%h,",
                         " got ok=%0d slot=%0d handle=%h"},
                        $time, want.ok, want.slot, want.handle,
                        got.ok, got.slot, got.handle);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      directed_row_type row;
      phase_type        ph;
      slot_result_type  typed_result;
      command_type      cmd;
      logic [IdxW-1:0]  idx;
      int               lim;
      int               pick;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: extremes, every command and the corner cases.
      for (int r = 0; r < NumRows; r++) begin
         row = directed_rows[r];
         if (row.is_cap) begin
            write_capacity(row.cap);
         end else begin
            typed_result = '{ok: row.ok, slot: row.slot, handle: row.handle};
            offer_command(row.cmd, row.idx, row.x, row.y, row.h, row.typed, typed_result);
         end
      end

      // Random phases. Most indexes address the slots in use so that commands hit
      // occupied entries; the rest fall above the capacity or anywhere in range.
      for (int p = 0; p < NumPhases; p++) begin
         ph = phases[p];
         write_capacity(ph.cap);
         sender_idle_pct    = ph.idle_pct;
         receiver_stall_pct = ph.stall_pct;
         for (int n = 0; n < ItemsPerPhase; n++) begin
            if (ph.hold_off && n == 10) hold_off_requests++;
            lim  = usable_slots();
            pick = $urandom_range(99);
            if (pick < 70 && lim > 0) idx = IdxW'($urandom_range(lim - 1));
            else if (pick < 85)       idx = IdxW'($urandom_range(255, lim));
            else                      idx = IdxW'($urandom_range(255));
            if ($urandom_range(99) < ph.add_pct) cmd = CmdAdd;
            else                                 cmd = command_type'($urandom_range(3, 1));
            offer_command(cmd, idx, PosW'($urandom), PosW'($urandom),
                          HandleW'($urandom), 1'b0, '0);
         end
      end

      drain_responses();
      // Any spurious response that arrives after the drain is caught before the verdict.
      repeat (5) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #8000000;
      $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/ffst_pkg.sv
design/first_free_slot_table_unit.sv
sim/testbench.sv
